### design/aarm_pkg.sv
// ----------------------------------------------------------------------------
// aarm_pkg: shared types and constants of the axis-angle rotation block
// Beat structs, angle constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none

package aarm_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_LEN         = 24;
  localparam int MOD_STEPS        = 14;   // 2*pi << 13 is the largest power-of-two multiple below 2^32
  localparam int TWO_PI_Q16       = 411775;
  localparam int PI_Q16           = 205887;
  localparam int HALF_PI_Q16      = 102944;
  localparam int GAIN_Q30         = 652032874;
  localparam int BETA_RESET       = 256;
  localparam int CW               = 34;   // CORDIC datapath width

  typedef struct packed {
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic        [15:0] step_size;
  } in_t;

  typedef struct packed {
    logic signed [15:0] entry_0;
    logic signed [15:0] entry_1;
    logic signed [15:0] entry_2;
    logic signed [15:0] entry_3;
    logic signed [15:0] entry_4;
    logic signed [15:0] entry_5;
    logic signed [15:0] entry_6;
    logic signed [15:0] entry_7;
    logic signed [15:0] entry_8;
  } out_t;

  function automatic logic signed [CW-1:0] atan_q30(input logic [4:0] i);
    logic signed [CW-1:0] v;
    case (i)
      5'd0:  v = CW'(843314857);
      5'd1:  v = CW'(497837829);
      5'd2:  v = CW'(263043837);
      5'd3:  v = CW'(133525159);
      5'd4:  v = CW'(67021687);
      5'd5:  v = CW'(33543516);
      5'd6:  v = CW'(16775851);
      5'd7:  v = CW'(8388437);
      5'd8:  v = CW'(4194283);
      5'd9:  v = CW'(2097149);
      5'd10: v = CW'(1048576);
      5'd11: v = CW'(524288);
      5'd12: v = CW'(262144);
      5'd13: v = CW'(131072);
      5'd14: v = CW'(65536);
      5'd15: v = CW'(32768);
      5'd16: v = CW'(16384);
      5'd17: v = CW'(8192);
      5'd18: v = CW'(4096);
      5'd19: v = CW'(2048);
      5'd20: v = CW'(1024);
      5'd21: v = CW'(512);
      5'd22: v = CW'(256);
      5'd23: v = CW'(128);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

### design/aarm_cordic.sv
// ----------------------------------------------------------------------------
// aarm_cordic: pipelined rotation-mode CORDIC
// One micro-rotation per register stage; x starts at the gain constant.
// ----------------------------------------------------------------------------
`default_nettype none

module aarm_cordic #(
  parameter int STEPS = aarm_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  input  wire logic signed [aarm_pkg::CW-1:0]   z_in,
  output logic                                  out_valid,
  output logic signed [aarm_pkg::CW-1:0]        x_out,
  output logic signed [aarm_pkg::CW-1:0]        y_out
);

  logic signed [aarm_pkg::CW-1:0] x [0:STEPS];
  logic signed [aarm_pkg::CW-1:0] y [0:STEPS];
  logic signed [aarm_pkg::CW-1:0] z [0:STEPS];
  logic                           v [0:STEPS];

  assign x[0] = aarm_pkg::CW'(aarm_pkg::GAIN_Q30);
  assign y[0] = '0;
  assign z[0] = z_in;
  assign v[0] = in_valid;

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else begin
        v[i+1] <= v[i];
      end
      if (z[i] >= 0) begin
        x[i+1] <= x[i] - (y[i] >>> i);
        y[i+1] <= y[i] + (x[i] >>> i);
        z[i+1] <= z[i] - aarm_pkg::atan_q30(5'(i));
      end else begin
        x[i+1] <= x[i] + (y[i] >>> i);
        y[i+1] <= y[i] - (x[i] >>> i);
        z[i+1] <= z[i] + aarm_pkg::atan_q30(5'(i));
      end
    end
  end

  assign out_valid = v[STEPS];
  assign x_out     = x[STEPS];
  assign y_out     = y[STEPS];

endmodule

`default_nettype wire

### design/axis_angle_rotation_matrix_top.sv
// ----------------------------------------------------------------------------
// axis_angle_rotation_matrix_top: Rodrigues rotation matrix pipeline
// Throughput: one beat per cycle; busy stays low, the pipeline never stalls.
// The depth is set by 14 modulo compare-subtract stages and one stage per
// CORDIC step. Synchronous reset clears all valid bits and sets the gain to 1.0.
// ----------------------------------------------------------------------------
`default_nettype none

module axis_angle_rotation_matrix_top #(
  parameter int CORDIC_STEPS = aarm_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  output logic                busy,
  input  wire aarm_pkg::in_t  item,
  input  wire logic           cfg_we,
  input  wire logic [15:0]    cfg_data,
  output logic                done,
  output aarm_pkg::out_t      result
);

  localparam int N   = (CORDIC_STEPS < aarm_pkg::ATAN_LEN) ? CORDIC_STEPS : aarm_pkg::ATAN_LEN;
  localparam int MS  = aarm_pkg::MOD_STEPS;
  localparam int LAT = 20 + N;

  typedef struct packed {
    logic               flip;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic signed [32:0] d0;
    logic signed [32:0] d4;
    logic signed [32:0] d8;
    logic signed [32:0] xy;
    logic signed [32:0] xz;
    logic signed [32:0] yz;
  } side_t;

  logic [15:0] beta;

  always_ff @(posedge clk) begin
    if (rst) begin
      beta <= 16'(aarm_pkg::BETA_RESET);
    end else if (cfg_we) begin
      beta <= cfg_data;
    end
  end

  assign busy = 1'b0;

  // modulo 2*pi by restoring compare-subtract, one multiple per stage
  logic [31:0]    rem [0:MS];
  logic           vm  [0:MS];
  aarm_pkg::in_t  am  [0:MS];

  always_ff @(posedge clk) begin
    if (rst) begin
      vm[0] <= 1'b0;
    end else begin
      vm[0] <= start && !busy;
    end
    rem[0] <= 32'(item.step_size) * 32'(beta);
    am[0]  <= item;
  end

  for (genvar k = 0; k < MS; k++) begin : g_mod
    localparam logic [32:0] M = 33'(aarm_pkg::TWO_PI_Q16) << (MS - 1 - k);
    always_ff @(posedge clk) begin
      if (rst) begin
        vm[k+1] <= 1'b0;
      end else begin
        vm[k+1] <= vm[k];
      end
      rem[k+1] <= ({1'b0, rem[k]} >= M) ? rem[k] - M[31:0] : rem[k];
      am[k+1]  <= am[k];
    end
  end

  // fold into [-pi/2, pi/2], form W*W terms
  logic signed [20:0] r0, r1;
  logic               flip_c;
  logic signed [31:0] sxx, syy, szz, pxy, pxz, pyz;
  logic signed [aarm_pkg::CW-1:0] z0;
  logic               vf;
  side_t              sf;

  always_comb begin
    r0 = $signed({2'b00, rem[MS][18:0]});
    if (r0 > $signed(21'(aarm_pkg::PI_Q16))) begin
      r0 = r0 - $signed(21'(aarm_pkg::TWO_PI_Q16));
    end
    flip_c = 1'b0;
    r1     = r0;
    if (r0 > $signed(21'(aarm_pkg::HALF_PI_Q16))) begin
      r1     = r0 - $signed(21'(aarm_pkg::PI_Q16));
      flip_c = 1'b1;
    end else if (r0 < -$signed(21'(aarm_pkg::HALF_PI_Q16))) begin
      r1     = r0 + $signed(21'(aarm_pkg::PI_Q16));
      flip_c = 1'b1;
    end
    sxx = am[MS].axis_x * am[MS].axis_x;
    syy = am[MS].axis_y * am[MS].axis_y;
    szz = am[MS].axis_z * am[MS].axis_z;
    pxy = am[MS].axis_x * am[MS].axis_y;
    pxz = am[MS].axis_x * am[MS].axis_z;
    pyz = am[MS].axis_y * am[MS].axis_z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vf <= 1'b0;
    end else begin
      vf <= vm[MS];
    end
    z0      <= aarm_pkg::CW'(r1) <<< 14;
    sf.flip <= flip_c;
    sf.ax   <= am[MS].axis_x;
    sf.ay   <= am[MS].axis_y;
    sf.az   <= am[MS].axis_z;
    sf.d0   <= -(33'(szz) + 33'(syy));
    sf.d4   <= -(33'(szz) + 33'(sxx));
    sf.d8   <= -(33'(syy) + 33'(sxx));
    sf.xy   <= 33'(pxy);
    sf.xz   <= 33'(pxz);
    sf.yz   <= 33'(pyz);
  end

  logic                           vc;
  logic signed [aarm_pkg::CW-1:0] xc, yc;

  aarm_cordic #(.STEPS(N)) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vf),
    .z_in      (z0),
    .out_valid (vc),
    .x_out     (xc),
    .y_out     (yc)
  );

  side_t sd [0:N];
  assign sd[0] = sf;
  for (genvar j = 0; j < N; j++) begin : g_side
    always_ff @(posedge clk) begin
      sd[j+1] <= sd[j];
    end
  end

  // sine and one minus cosine
  logic               vs;
  logic signed [34:0] s_r, c1_r;
  side_t              ss;

  always_ff @(posedge clk) begin
    if (rst) begin
      vs <= 1'b0;
    end else begin
      vs <= vc;
    end
    s_r  <= sd[N].flip ? -35'(yc) : 35'(yc);
    c1_r <= (35'sd1 <<< 30) - (sd[N].flip ? -35'(xc) : 35'(xc));
    ss   <= sd[N];
  end

  // products per entry
  logic signed [16:0] w   [0:8];
  logic signed [32:0] ww  [0:8];
  logic signed [51:0] psw [0:8];
  logic signed [51:0] phi [0:8];
  logic signed [51:0] plo [0:8];
  logic signed [22:0] rnd [0:8];
  logic signed [15:0] sat [0:8];
  logic               v1, v2;

  always_comb begin
    w[0] = '0;               w[1] = 17'(ss.az);       w[2] = -17'(ss.ay);
    w[3] = -17'(ss.az);      w[4] = '0;               w[5] = 17'(ss.ax);
    w[6] = 17'(ss.ay);       w[7] = -17'(ss.ax);      w[8] = '0;
    ww[0] = ss.d0; ww[1] = ss.xy; ww[2] = ss.xz;
    ww[3] = ss.xy; ww[4] = ss.d4; ww[5] = ss.yz;
    ww[6] = ss.xz; ww[7] = ss.yz; ww[8] = ss.d8;
  end

  for (genvar e = 0; e < 9; e++) begin : g_ent
    localparam bit DIAG = (e == 0) || (e == 4) || (e == 8);
    logic signed [16:0] wh;
    logic signed [16:0] wl;
    logic signed [55:0] acc;
    assign wh = ww[e][32:16];
    assign wl = $signed({1'b0, ww[e][15:0]});

    always_ff @(posedge clk) begin
      psw[e] <= 52'(s_r * w[e]);
      phi[e] <= 52'(c1_r * wh);
      plo[e] <= 52'(c1_r * wl);
    end

    // floor(c1*ww/2^15) = 2*c1*wh + floor(c1*wl/2^15), exact since wl is the low half
    always_comb begin
      acc = (DIAG ? (56'sd1 <<< 45) : 56'sd0) + 56'(psw[e]) + (56'(phi[e]) <<< 1)
          + 56'(plo[e] >>> 15) + (56'sd1 <<< 29);
    end

    always_ff @(posedge clk) begin
      rnd[e] <= 23'(acc >>> 30);
      if (rnd[e] > 23'sd32767) begin
        sat[e] <= 16'sh7fff;
      end else if (rnd[e] < -23'sd32768) begin
        sat[e] <= 16'sh8000;
      end else begin
        sat[e] <= rnd[e][15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= vs;
      v2   <= v1;
      done <= v2;
    end
  end

  assign result.entry_0 = sat[0];
  assign result.entry_1 = sat[1];
  assign result.entry_2 = sat[2];
  assign result.entry_3 = sat[3];
  assign result.entry_4 = sat[4];
  assign result.entry_5 = sat[5];
  assign result.entry_6 = sat[6];
  assign result.entry_7 = sat[7];
  assign result.entry_8 = sat[8];

  a_done_lat: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("done without a beat accepted LAT cycles earlier");

  a_rst_done: assert property (@(posedge clk) rst |=> !done)
    else $error("done after reset");

  a_mod_range: assert property (@(posedge clk) disable iff (rst)
    vm[MS] |-> (rem[MS] < 32'(aarm_pkg::TWO_PI_Q16)))
    else $error("angle not reduced below 2*pi");

  a_cordic_align: assert property (@(posedge clk) disable iff (rst)
    vc |-> $past(vf, N))
    else $error("CORDIC valid out of step with side data");

endmodule

`default_nettype wire
